### src/rmsb_pkg.sv
// ----------------------------------------------------------------------------
// rmsb_pkg
// Shared types and constants for the blocked range-maximum core.
// ----------------------------------------------------------------------------
package rmsb_pkg;

  localparam int DATA_W  = 32;
  localparam int IDX_W   = 12;
  localparam int BOUND_W = 13;
  localparam int CNT_W   = 13;

  typedef logic signed [DATA_W-1:0] data_t;

  localparam logic [CNT_W-1:0] CNT_RESET = 13'd4096;
  // minus two to the thirtieth, result of an empty range
  localparam data_t EMPTY_MAX = 32'shC000_0000;

  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  // one control word worth of datapath actions
  typedef struct packed {
    logic wr_el;
    logic init_upd;
    logic rd_el_cur;
    logic inc_cur;
    logic rd_el_hi;
    logic dec_hi;
    logic rd_blk;
    logic add_bs;
    logic wr_blk;
    logic init_qry;
    logic load_out;
    logic fin;
  } act_t;

  // datapath flags tested by the sequencer
  typedef struct packed {
    logic cur_lt_stop;
    logic head;
    logic tail;
    logic cur_lt_hi;
  } status_t;

endpackage

### src/rmsb_in_if.sv
// ----------------------------------------------------------------------------
// rmsb_in_if
// Request channel: update or range query, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rmsb_in_if;
  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic [rmsb_pkg::IDX_W-1:0]    element_index;
  rmsb_pkg::data_t               new_value;
  logic [rmsb_pkg::BOUND_W-1:0]  range_start;
  logic [rmsb_pkg::BOUND_W-1:0]  range_end;

  modport source (
    output valid, cmd, element_index, new_value, range_start, range_end,
    input  ready
  );
  modport sink (
    input  valid, cmd, element_index, new_value, range_start, range_end,
    output ready
  );
endinterface

### src/rmsb_out_if.sv
// ----------------------------------------------------------------------------
// rmsb_out_if
// Result channel: range maximum, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rmsb_out_if;
  logic            valid;
  logic            ready;
  rmsb_pkg::data_t max_value;

  modport source (output valid, max_value, input ready);
  modport sink (input valid, max_value, output ready);
endinterface

### src/rmsb_cfg_if.sv
// ----------------------------------------------------------------------------
// rmsb_cfg_if
// Configuration write channel for the element count register.
// ----------------------------------------------------------------------------
interface rmsb_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [rmsb_pkg::CNT_W-1:0]  element_count;

  modport source (output valid, element_count, input ready);
  modport sink (input valid, element_count, output ready);
endinterface

### src/rmsb_seq.sv
// ----------------------------------------------------------------------------
// rmsb_seq
// Microcode sequencer: control store, step counter and conditional jumps.
// ----------------------------------------------------------------------------
module rmsb_seq (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              qry,
  input  rmsb_pkg::status_t status,
  input  logic              out_free,
  output rmsb_pkg::act_t    act,
  output logic              busy
);
  import rmsb_pkg::*;

  typedef logic [2:0] upc_t;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_CUR_LT_STOP,
    C_HEAD,
    C_TAIL,
    C_CUR_LT_HI,
    C_OUT_FREE
  } cond_t;

  typedef struct packed {
    cond_t cond;
    upc_t  nxt_t;
    upc_t  nxt_f;
    act_t  act;
  } ucode_t;

  localparam upc_t UA_U_INIT  = 3'd0;
  localparam upc_t UA_U_SCAN  = 3'd1;
  localparam upc_t UA_U_WRBLK = 3'd2;
  localparam upc_t UA_Q_INIT  = 3'd3;
  localparam upc_t UA_Q_HEAD  = 3'd4;
  localparam upc_t UA_Q_TAIL  = 3'd5;
  localparam upc_t UA_Q_BLKS  = 3'd6;
  localparam upc_t UA_Q_OUT   = 3'd7;

  // actions run only when the step's condition holds
  function automatic ucode_t ucode_rom(upc_t a);
    ucode_t w;
    w = '0;
    case (a)
      UA_U_INIT: begin
        w.cond = C_ALWAYS;   w.nxt_t = UA_U_SCAN;  w.nxt_f = UA_U_SCAN;
        w.act.wr_el = 1'b1;  w.act.init_upd = 1'b1;
      end
      UA_U_SCAN: begin
        w.cond = C_CUR_LT_STOP; w.nxt_t = UA_U_SCAN; w.nxt_f = UA_U_WRBLK;
        w.act.rd_el_cur = 1'b1; w.act.inc_cur = 1'b1;
      end
      UA_U_WRBLK: begin
        w.cond = C_ALWAYS;   w.nxt_t = UA_U_INIT;  w.nxt_f = UA_U_INIT;
        w.act.wr_blk = 1'b1; w.act.fin = 1'b1;
      end
      UA_Q_INIT: begin
        w.cond = C_ALWAYS;   w.nxt_t = UA_Q_HEAD;  w.nxt_f = UA_Q_HEAD;
        w.act.init_qry = 1'b1;
      end
      UA_Q_HEAD: begin
        w.cond = C_HEAD;     w.nxt_t = UA_Q_HEAD;  w.nxt_f = UA_Q_TAIL;
        w.act.rd_el_cur = 1'b1; w.act.inc_cur = 1'b1;
      end
      UA_Q_TAIL: begin
        w.cond = C_TAIL;     w.nxt_t = UA_Q_TAIL;  w.nxt_f = UA_Q_BLKS;
        w.act.rd_el_hi = 1'b1; w.act.dec_hi = 1'b1;
      end
      UA_Q_BLKS: begin
        w.cond = C_CUR_LT_HI; w.nxt_t = UA_Q_BLKS; w.nxt_f = UA_Q_OUT;
        w.act.rd_blk = 1'b1; w.act.add_bs = 1'b1;
      end
      UA_Q_OUT: begin
        w.cond = C_OUT_FREE; w.nxt_t = UA_U_INIT;  w.nxt_f = UA_Q_OUT;
        w.act.load_out = 1'b1; w.act.fin = 1'b1;
      end
      default: w = '0;
    endcase
    return w;
  endfunction

  upc_t   upc;
  ucode_t uw;
  logic   cond_ok;

  assign uw = ucode_rom(upc);

  always_comb begin
    case (uw.cond)
      C_ALWAYS:      cond_ok = 1'b1;
      C_CUR_LT_STOP: cond_ok = status.cur_lt_stop;
      C_HEAD:        cond_ok = status.head;
      C_TAIL:        cond_ok = status.tail;
      C_CUR_LT_HI:   cond_ok = status.cur_lt_hi;
      C_OUT_FREE:    cond_ok = out_free;
      default:       cond_ok = 1'b0;
    endcase
  end

  assign act = (busy && cond_ok) ? uw.act : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      upc  <= UA_U_INIT;
    end else if (start) begin
      busy <= 1'b1;
      upc  <= qry ? UA_Q_INIT : UA_U_INIT;
    end else if (busy) begin
      if (cond_ok) begin
        upc <= uw.nxt_t;
        if (uw.act.fin) begin
          busy <= 1'b0;
        end
      end else begin
        upc <= uw.nxt_f;
      end
    end
  end

endmodule

### src/rmsb_dp.sv
// ----------------------------------------------------------------------------
// rmsb_dp
// Datapath: element and block-maximum memories, pointers, running maximum.
// ----------------------------------------------------------------------------
module rmsb_dp #(
  parameter int MAX_ELEMENTS = 4096,
  parameter int BLOCK_SIZE   = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [rmsb_pkg::IDX_W-1:0]    element_index,
  input  rmsb_pkg::data_t               new_value,
  input  logic [rmsb_pkg::BOUND_W-1:0]  range_start,
  input  logic [rmsb_pkg::BOUND_W-1:0]  range_end,
  input  logic [rmsb_pkg::CNT_W-1:0]    element_count,
  input  rmsb_pkg::act_t                act,
  output rmsb_pkg::status_t             status,
  output rmsb_pkg::data_t               acc,
  output logic                          clr_busy
);
  import rmsb_pkg::*;

  // block size is a power of two
  localparam int LOG = $clog2(BLOCK_SIZE);
  localparam int NB  = (MAX_ELEMENTS + BLOCK_SIZE - 1) / BLOCK_SIZE;
  localparam int BKW = (NB > 1) ? $clog2(NB) : 1;
  localparam int EW  = $clog2(MAX_ELEMENTS);
  localparam int AW  = (EW + 2 > CNT_W) ? EW + 2 : CNT_W;

  data_t el_mem  [MAX_ELEMENTS];
  data_t blk_mem [NB];
  data_t el_rdata;
  data_t blk_rdata;

  logic [AW-1:0]      idx_q;
  data_t              val_q;
  logic [BOUND_W-1:0] rs_q;
  logic [BOUND_W-1:0] re_q;
  logic [AW-1:0]      cur;
  logic [AW-1:0]      stop;
  logic [AW-1:0]      hi;
  logic               pend_el;
  logic               pend_blk;
  logic [EW-1:0]      clr_addr;

  logic [AW-1:0]  lim;
  logic [AW-1:0]  base;
  logic [AW-1:0]  blk_end;
  logic [AW-1:0]  stop_next;
  logic [AW-1:0]  lo_sat;
  logic [AW-1:0]  hi_sat;
  logic [AW-1:0]  hi_m1;
  logic [EW-1:0]  el_raddr;
  logic [BKW-1:0] upd_blk;
  logic [BKW-1:0] rd_blk_addr;
  logic           clr_in_blk;
  data_t          fold_val;
  logic           fold_en;

  assign lim = (AW'(element_count) < AW'(MAX_ELEMENTS)) ? AW'(element_count)
                                                        : AW'(MAX_ELEMENTS);
  assign base      = (idx_q >> LOG) << LOG;
  assign blk_end   = base + AW'(BLOCK_SIZE);
  assign stop_next = (blk_end < lim) ? blk_end : lim;
  assign lo_sat = (AW'(rs_q) > AW'(MAX_ELEMENTS)) ? AW'(MAX_ELEMENTS) : AW'(rs_q);
  assign hi_sat = (AW'(re_q) > AW'(MAX_ELEMENTS)) ? AW'(MAX_ELEMENTS) : AW'(re_q);
  assign hi_m1  = hi - AW'(1);

  assign el_raddr    = act.rd_el_hi ? hi_m1[EW-1:0] : cur[EW-1:0];
  assign upd_blk     = idx_q[LOG +: BKW];
  assign rd_blk_addr = cur[LOG +: BKW];
  assign clr_in_blk  = AW'(clr_addr) < AW'(NB);

  // reads of the two memories never overlap, so one source folds per cycle
  assign fold_val = pend_blk ? blk_rdata : el_rdata;
  assign fold_en  = pend_el | pend_blk;

  assign status.cur_lt_stop = cur < stop;
  assign status.cur_lt_hi   = cur < hi;
  assign status.head = (cur < hi) && (cur[LOG-1:0] != '0);
  assign status.tail = (cur < hi) && (hi[LOG-1:0] != '0);

  always_ff @(posedge clk) begin
    if (clr_busy) begin
      el_mem[clr_addr] <= '0;
    end else if (act.wr_el) begin
      el_mem[idx_q[EW-1:0]] <= val_q;
    end
    el_rdata <= el_mem[el_raddr];
  end

  always_ff @(posedge clk) begin
    if (clr_busy) begin
      if (clr_in_blk) begin
        blk_mem[clr_addr[BKW-1:0]] <= '0;
      end
    end else if (act.wr_blk) begin
      blk_mem[upd_blk] <= acc;
    end
    blk_rdata <= blk_mem[rd_blk_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
      pend_el  <= 1'b0;
      pend_blk <= 1'b0;
    end else begin
      pend_el  <= act.rd_el_cur | act.rd_el_hi;
      pend_blk <= act.rd_blk;
      if (clr_busy) begin
        if (clr_addr == EW'(MAX_ELEMENTS - 1)) begin
          clr_busy <= 1'b0;
        end else begin
          clr_addr <= clr_addr + EW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      idx_q <= AW'(element_index);
      val_q <= new_value;
      rs_q  <= range_start;
      re_q  <= range_end;
    end
    if (act.init_upd) begin
      cur  <= base;
      stop <= stop_next;
    end else if (act.init_qry) begin
      cur <= lo_sat;
    end else if (act.inc_cur) begin
      cur <= cur + AW'(1);
    end else if (act.add_bs) begin
      cur <= cur + AW'(BLOCK_SIZE);
    end
    if (act.init_qry) begin
      hi <= hi_sat;
    end else if (act.dec_hi) begin
      hi <= hi_m1;
    end
    if (act.init_upd) begin
      acc <= val_q;
    end else if (act.init_qry) begin
      acc <= EMPTY_MAX;
    end else if (fold_en && (fold_val > acc)) begin
      acc <= fold_val;
    end
  end

endmodule

### src/range_max_sqrt_blocks_core.sv
// ----------------------------------------------------------------------------
// range_max_sqrt_blocks_core
// Update writes the element, scans the n elements of its block below the count
// (at most BLOCK_SIZE), one element-memory read per cycle, then writes the block maximum.
// Query reads h head and t tail partial elements, then b whole blocks, one
// memory read each, before loading its result register.
// One request at a time; a waiting result does not block the next request.
// Reset clears both memories with requests held off.
// ----------------------------------------------------------------------------
module range_max_sqrt_blocks_core #(
  parameter int MAX_ELEMENTS = 4096,
  parameter int BLOCK_SIZE   = 256
) (
  input logic        clk,
  input logic        rst,
  rmsb_in_if.sink    item,
  rmsb_out_if.source result,
  rmsb_cfg_if.sink   cfg
);
  import rmsb_pkg::*;

  logic [CNT_W-1:0] element_count;
  logic             out_valid;
  data_t            out_data;
  logic             busy;
  logic             clr_busy;
  logic             accept;
  logic             upd_skip;
  logic             start;
  logic             out_free;
  act_t             act;
  status_t          status;
  data_t            acc;

  assign item.ready = !busy && !clr_busy;
  assign cfg.ready  = 1'b1;
  assign accept     = item.valid && item.ready;
  // updates past the array are dropped
  assign upd_skip = (item.cmd == CMD_UPDATE) && (int'(item.element_index) >= MAX_ELEMENTS);
  assign start    = accept && !upd_skip;
  assign out_free = !out_valid || result.ready;

  assign result.valid     = out_valid;
  assign result.max_value = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      element_count <= CNT_RESET;
    end else if (cfg.valid && cfg.ready) begin
      element_count <= cfg.element_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (act.load_out) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (act.load_out) begin
      out_data <= acc;
    end
  end

  rmsb_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .qry      (item.cmd == CMD_QUERY),
    .status   (status),
    .out_free (out_free),
    .act      (act),
    .busy     (busy)
  );

  rmsb_dp #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .BLOCK_SIZE   (BLOCK_SIZE)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .element_index (item.element_index),
    .new_value     (item.new_value),
    .range_start   (item.range_start),
    .range_end     (item.range_end),
    .element_count (element_count),
    .act           (act),
    .status        (status),
    .acc           (acc),
    .clr_busy      (clr_busy)
  );

endmodule

### src/rmsb_check.sv
// ----------------------------------------------------------------------------
// rmsb_check
// Port-level checks for the range-maximum core, bound to the top level.
// ----------------------------------------------------------------------------
module rmsb_check (
  input logic            clk,
  input logic            rst,
  input logic            item_valid,
  input logic            item_ready,
  input logic            item_cmd,
  input logic            result_valid,
  input logic            result_ready,
  input rmsb_pkg::data_t result_max_value
);
  import rmsb_pkg::*;

  // clearing pass holds requests off right after reset
  a_clear_after_reset: assert property (@(posedge clk)
    $fell(rst) |-> !item_ready)
    else $error("request accepted during clearing pass");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready && item_cmd == CMD_QUERY) |=> !item_ready)
    else $error("query did not occupy the core");

  a_query_no_early_result: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready && item_cmd == CMD_QUERY) |=> !$rose(result_valid))
    else $error("result appeared too early after a query");

  a_update_no_result: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready && item_cmd == CMD_UPDATE) |=> !$rose(result_valid))
    else $error("update produced a result");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=> (result_valid && $stable(result_max_value)))
    else $error("stalled result changed");

endmodule

bind range_max_sqrt_blocks_core rmsb_check u_rmsb_check (
  .clk              (clk),
  .rst              (rst),
  .item_valid       (item.valid),
  .item_ready       (item.ready),
  .item_cmd         (item.cmd),
  .result_valid     (result.valid),
  .result_ready     (result.ready),
  .result_max_value (result.max_value)
);

### tb/range_max_sqrt_blocks_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// range_max_sqrt_blocks_core_tb
// Drives element updates and range-maximum queries through the valid/ready
// channels, predicts every query result from a blocked copy of the array,
// and checks results in order. The element count is changed between phases
// while the core is idle, covering zero, the array size and the 13-bit top.
// ----------------------------------------------------------------------------
module range_max_sqrt_blocks_core_tb;
  import rmsb_pkg::*;

  localparam int N_ELEM          = 4096;
  localparam int BLK             = 256;
  localparam int N_BLK           = N_ELEM / BLK;
  localparam int IDLE_PCT        = 31;
  localparam int SETTLE_CYCLES   = 600;
  localparam int ITEMS_PER_PHASE = 125;
  localparam int N_PHASES        = 9;

  class range_max_scoreboard;
    data_t            elements[N_ELEM];
    data_t            block_max[N_BLK];
    logic [CNT_W-1:0] elem_count;
    data_t            pending_max[$];
    int               errors;

    function new();
      foreach (elements[i]) elements[i] = '0;
      foreach (block_max[i]) block_max[i] = '0;
      elem_count = CNT_RESET;
      errors = 0;
    endfunction

    function void set_count(logic [CNT_W-1:0] cnt);
      elem_count = cnt;
    endfunction

    function data_t range_max(int lo, int hi);
      data_t m;
      int    be;
      m = EMPTY_MAX;
      if (lo > N_ELEM) lo = N_ELEM;
      if (hi > N_ELEM) hi = N_ELEM;
      // head elements up to the first block edge
      while (lo < hi && (lo % BLK) != 0) begin
        if (elements[lo] > m) m = elements[lo];
        lo++;
      end
      // tail elements down to the last block edge
      while (lo < hi && (hi % BLK) != 0) begin
        hi--;
        if (elements[hi] > m) m = elements[hi];
      end
      be = hi / BLK;
      for (int b = lo / BLK; b < be && b < N_BLK; b++)
        if (block_max[b] > m) m = block_max[b];
      return m;
    endfunction

    function void write_element(int idx, data_t val);
      int    lim;
      int    first;
      int    stop;
      data_t m;
      lim = (elem_count < N_ELEM) ? int'(elem_count) : N_ELEM;
      elements[idx] = val;
      first = (idx / BLK) * BLK;
      stop = first + BLK;
      if (stop > lim) stop = lim;
      // new value always counts, even when its index is past the count
      m = val;
      for (int p = first; p < stop; p++)
        if (elements[p] > m) m = elements[p];
      block_max[idx / BLK] = m;
    endfunction

    function void note_request(logic cmd, logic [IDX_W-1:0] idx, data_t val,
                               logic [BOUND_W-1:0] rs, logic [BOUND_W-1:0] re);
      if (cmd == CMD_UPDATE) write_element(int'(idx), val);
      else pending_max.push_back(range_max(int'(rs), int'(re)));
    endfunction

    task report(string msg);
      errors++;
      $display("%0t: %s", $time, msg);
    endtask

    task check_result(data_t got);
      data_t want;
      if (pending_max.size() == 0) begin
        report($sformatf("unexpected result max_value=%0d", got));
      end else begin
        want = pending_max.pop_front();
        if (got !== want)
          report($sformatf("max_value mismatch: got %0d, want %0d", got, want));
      end
    endtask
  endclass

  logic clk;
  logic rst;

  rmsb_in_if  item_if ();
  rmsb_out_if res_if ();
  rmsb_cfg_if cfg_if ();

  range_max_scoreboard sb = new();

  bit no_idle;
  int stall_request;
  int stall_left;

  range_max_sqrt_blocks_core u_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_if),
    .result (res_if),
    .cfg    (cfg_if)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #40_000_000;
    $display("range_max_sqrt_blocks_core_tb: errors");
    $finish;
  end

  // result side: checks each accepted result, random back-pressure
  initial begin
    res_if.ready <= 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (res_if.valid && res_if.ready) sb.check_result(res_if.max_value);
      if (stall_request != 0) begin
        stall_left = stall_request;
        stall_request = 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  task automatic send_request(logic cmd, logic [IDX_W-1:0] idx, data_t val,
                              logic [BOUND_W-1:0] rs, logic [BOUND_W-1:0] re,
                              bit allow_gap);
    if (allow_gap) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        item_if.valid <= 1'b0;
        @(posedge clk);
      end
    end
    item_if.valid         <= 1'b1;
    item_if.cmd           <= cmd;
    item_if.element_index <= idx;
    item_if.new_value     <= val;
    item_if.range_start   <= rs;
    item_if.range_end     <= re;
    @(posedge clk);
    while (!item_if.ready) @(posedge clk);
    sb.note_request(cmd, idx, val, rs, re);
  endtask

  // unused fields carry junk so the core must ignore them
  task automatic send_update(int idx, data_t val, bit allow_gap = 1'b1);
    send_request(CMD_UPDATE, IDX_W'(idx), val, BOUND_W'($urandom),
                 BOUND_W'($urandom), allow_gap);
  endtask

  task automatic send_query(int rs, int re, bit allow_gap = 1'b1);
    send_request(CMD_QUERY, IDX_W'($urandom), data_t'($urandom), BOUND_W'(rs),
                 BOUND_W'(re), allow_gap);
  endtask

  task automatic wait_drained();
    item_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_max.size() != 0) @(posedge clk);
  endtask

  task automatic write_count(logic [CNT_W-1:0] cnt);
    wait_drained();
    // an update still in flight gives no result to wait for
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_if.valid         <= 1'b1;
    cfg_if.element_count <= cnt;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    sb.set_count(cnt);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic random_update(bit allow_gap);
    int    idx;
    int    r;
    data_t val;
    r = $urandom_range(99);
    if (r < 30 && sb.elem_count < N_ELEM) begin
      // near the end of the elements in use
      idx = int'(sb.elem_count) + $urandom_range(8) - 4;
      if (idx < 0) idx = 0;
      if (idx > N_ELEM - 1) idx = N_ELEM - 1;
    end else begin
      idx = $urandom_range(N_ELEM - 1);
    end
    r = $urandom_range(99);
    if (r < 80) val = data_t'($urandom);
    else if (r < 85) val = 32'sh7FFF_FFFF;
    else if (r < 90) val = 32'sh8000_0000;
    else val = data_t'($urandom_range(2000)) - 1000;
    send_update(idx, val, allow_gap);
  endtask

  task automatic random_query(bit allow_gap);
    int rs;
    int re;
    int r;
    r = $urandom_range(99);
    if (r < 50) begin
      rs = $urandom_range(N_ELEM);
      re = rs + $urandom_range(40);
    end else if (r < 72) begin
      rs = $urandom_range(N_ELEM);
      re = $urandom_range(N_ELEM, rs);
    end else if (r < 88) begin
      rs = $urandom_range(8191);
      re = $urandom_range(8191);
    end else begin
      rs = $urandom_range(N_BLK) * BLK;
      re = $urandom_range(N_BLK) * BLK;
    end
    send_query(rs, re, allow_gap);
  endtask

  initial begin
    logic [CNT_W-1:0] phase_counts[N_PHASES];
    int               idx;
    bit               allow_gap;

    rst                   <= 1'b1;
    item_if.valid         <= 1'b0;
    item_if.cmd           <= CMD_UPDATE;
    item_if.element_index <= '0;
    item_if.new_value     <= '0;
    item_if.range_start   <= '0;
    item_if.range_end     <= '0;
    cfg_if.valid          <= 1'b0;
    cfg_if.element_count  <= CNT_RESET;
    no_idle       = 1'b0;
    stall_request = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    write_count(CNT_RESET);

    // directed: cleared store, empty and saturated ranges, extremes
    send_query(0, N_ELEM);
    send_query(0, 0);
    send_query(5, 3);
    send_query(8191, 8191);
    send_query(N_ELEM, 0);
    send_update(0, 32'sh7FFF_FFFF);
    send_update(N_ELEM - 1, 32'sh8000_0000);
    send_update(255, -5);
    send_update(256, 12345);
    send_update(1000, 32'shAAAA_AAAA);
    send_update(3071, 32'sh5555_5555);
    send_query(0, 1);
    send_query(N_ELEM - 1, N_ELEM);
    send_query(0, 8191);
    send_query(255, 257);
    send_query(1, N_ELEM - 1);
    send_query(256, 512);
    send_query(1000, 1001);
    send_query(3000, 8000);
    send_query(3072, 8191);
    send_query(8190, 4000);

    phase_counts = '{13'd0, 13'd8191, 13'd1, 13'd300, 13'd4095, 13'd0,
                     13'd4096, 13'd0, 13'd256};
    phase_counts[5] = CNT_W'($urandom_range(1, N_ELEM));
    phase_counts[7] = CNT_W'($urandom_range(1, N_ELEM));

    for (int ph = 0; ph < N_PHASES; ph++) begin
      write_count(phase_counts[ph]);
      no_idle = (ph == 6);
      allow_gap = !no_idle;

      // fresh write, then read its whole block back from the block store
      idx = $urandom_range(N_ELEM - 1);
      send_update(idx, data_t'($urandom), allow_gap);
      send_query((idx / BLK) * BLK, (idx / BLK + 1) * BLK, allow_gap);

      if (ph == 3) begin
        // long result hold-off while requests keep coming with no gaps
        stall_request = 3000;
        for (int k = 0; k < 20; k++) begin
          idx = $urandom_range(N_ELEM - 2);
          send_query(idx, idx + $urandom_range(1, 12), 1'b0);
        end
      end

      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if ($urandom_range(99) < 45) random_update(allow_gap);
        else random_query(allow_gap);
        // occasionally hold requests until all results are back
        if ((ph == 1 && k == ITEMS_PER_PHASE / 2) || $urandom_range(63) == 0)
          wait_drained();
      end
    end

    wait_drained();
    no_idle = 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending_max.size() == 0) begin
      $display("range_max_sqrt_blocks_core_tb: clean");
    end else begin
      $display("range_max_sqrt_blocks_core_tb: errors");
    end
    $finish;
  end

endmodule
